[hw/rtl/sjf_pkg.sv]
// Shared constants, record and control types for the shortest-job-first scheduler.
`default_nettype none

package sjf_pkg;

	// Capacity of the process store and derived index widths.
	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);

	// Field widths of the transactions.
	localparam int ID_W   = 8;
	localparam int TIME_W = 16;
	localparam int TICK_W = 21;
	localparam int SUM_W  = 25;

	// One stored process record.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] arrival;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_init;
		logic scan_issue;
		logic calc;
		logic emit;
		logic clear;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic issue_last;
		logic last_pick;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/sjf_job_if.sv]
// Channel interface that carries process records into the scheduler.
`default_nettype none

interface sjf_job_if;
	logic                        valid;
	logic                        ready;
	logic [sjf_pkg::ID_W-1:0]    proc_id;
	logic [sjf_pkg::TIME_W-1:0]  burst_time;
	logic [sjf_pkg::TIME_W-1:0]  arrival_time;
	logic                        final_record;

	modport source (output valid, proc_id, burst_time, arrival_time, final_record, input ready);
	modport sink   (input valid, proc_id, burst_time, arrival_time, final_record, output ready);
endinterface

`default_nettype wire

[hw/rtl/sjf_run_if.sv]
// Channel interface that carries schedule results out of the scheduler.
`default_nettype none

interface sjf_run_if;
	logic                        valid;
	logic                        ready;
	logic [sjf_pkg::ID_W-1:0]    run_id;
	logic [sjf_pkg::TIME_W-1:0]  run_burst;
	logic [sjf_pkg::TICK_W-1:0]  start_tick;
	logic [sjf_pkg::TICK_W-1:0]  finish_tick;
	logic [sjf_pkg::TICK_W-1:0]  wait_ticks;
	logic [sjf_pkg::TICK_W-1:0]  turnaround_ticks;
	logic [sjf_pkg::SUM_W-1:0]   wait_total;
	logic [sjf_pkg::SUM_W-1:0]   turnaround_total;
	logic                        run_last;

	modport source (output valid, run_id, run_burst, start_tick, finish_tick, wait_ticks,
		turnaround_ticks, wait_total, turnaround_total, run_last, input ready);
	modport sink   (input valid, run_id, run_burst, start_tick, finish_tick, wait_ticks,
		turnaround_ticks, wait_total, turnaround_total, run_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/sjf_ctrl.sv]
// Controller state machine that sequences loading, scanning and result emission.
`default_nettype none

module sjf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_valid,
	input  wire logic             job_final,
	output logic                  job_ready,
	input  wire sjf_pkg::status_t sts,
	output sjf_pkg::cmd_t         cmd
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_CALC  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Command decode from the current state and handshake status.
	always_comb begin
		job_ready      = (state_q == ST_LOAD);
		cmd.load       = job_valid && job_ready;
		cmd.scan_issue = (state_q == ST_SCAN);
		cmd.calc       = (state_q == ST_CALC);
		cmd.emit       = (state_q == ST_EMIT) && sts.out_free;
		cmd.clear      = cmd.emit && sts.last_pick;
		cmd.scan_init  = (cmd.load && job_final) || (cmd.emit && !sts.last_pick);
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (cmd.load && job_final) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_CALC;
			end
			ST_CALC: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.emit) begin
					state_d = sts.last_pick ? ST_LOAD : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sjf_dp.sv]
// Datapath: process store, selection scan, timing arithmetic and result register.
`default_nettype none

module sjf_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sjf_pkg::cmd_t               cmd,
	output sjf_pkg::status_t                 sts,
	input  wire logic [sjf_pkg::ID_W-1:0]    proc_id,
	input  wire logic [sjf_pkg::TIME_W-1:0]  burst_time,
	input  wire logic [sjf_pkg::TIME_W-1:0]  arrival_time,
	sjf_run_if.source                        run
);

	localparam int N      = sjf_pkg::MAX_PROCS;
	localparam int IDX_W  = sjf_pkg::IDX_W;
	localparam int CNT_W  = sjf_pkg::CNT_W;
	localparam int TIME_W = sjf_pkg::TIME_W;
	localparam int TICK_W = sjf_pkg::TICK_W;
	localparam int SUM_W  = sjf_pkg::SUM_W;

	// Process store, one record per entry.
	sjf_pkg::entry_t mem [N];

	// Batch control state.
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  emitted_q;
	logic [IDX_W-1:0]  idx_q;
	logic [N-1:0]      done_q;
	logic [TICK_W-1:0] clock_q;
	logic [SUM_W-1:0]  wait_sum_q;
	logic [SUM_W-1:0]  turn_sum_q;

	// Scan pipeline stage after the registered memory read.
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	sjf_pkg::entry_t   rd_s1;

	// Best arrived candidate and earliest-arrival fallback candidate.
	logic              have_best_q;
	sjf_pkg::entry_t   best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              have_min_q;
	sjf_pkg::entry_t   min_q;
	logic [IDX_W-1:0]  min_idx_q;

	// Computed times of the chosen job.
	sjf_pkg::entry_t   sel_q;
	logic [IDX_W-1:0]  sel_idx_q;
	logic [TICK_W-1:0] start_q;
	logic [TICK_W-1:0] finish_q;
	logic [TICK_W-1:0] wait_q;
	logic [TICK_W-1:0] turn_q;

	// Result register.
	logic              out_valid_q;

	logic              store_room;
	logic              cand_done;
	logic              cand_arrived;
	logic              take_best;
	logic              take_min;
	sjf_pkg::entry_t   pick_c;
	logic [IDX_W-1:0]  pick_idx_c;
	logic [TICK_W-1:0] pick_start_c;
	logic [TICK_W-1:0] pick_arr_c;
	logic [TICK_W-1:0] pick_burst_c;

	assign store_room = (count_q < CNT_W'(N));

	// Status toward the controller.
	always_comb begin
		sts.issue_last = ({1'b0, idx_q} == (count_q - CNT_W'(1)));
		sts.last_pick  = ((emitted_q + CNT_W'(1)) == count_q);
		sts.out_free   = !out_valid_q || run.ready;
	end

	// Store write on each accepted record while there is room.
	always_ff @(posedge clk) begin
		if (cmd.load && store_room) begin
			mem[count_q[IDX_W-1:0]] <= '{id: proc_id, burst: burst_time, arrival: arrival_time};
		end
	end

	// Registered store read for the scan.
	always_ff @(posedge clk) begin
		if (cmd.scan_issue) begin
			rd_s1  <= mem[idx_q];
			idx_s1 <= idx_q;
		end
	end

	// Candidate comparison on the entry that comes out of the read stage.
	always_comb begin
		cand_done    = done_q[idx_s1];
		cand_arrived = !cand_done && ({{(TICK_W-TIME_W){1'b0}}, rd_s1.arrival} <= clock_q);
		take_best    = vld_s1 && cand_arrived && (!have_best_q ||
			(rd_s1.burst < best_q.burst) ||
			((rd_s1.burst == best_q.burst) && (rd_s1.arrival < best_q.arrival)));
		take_min     = vld_s1 && !cand_done && (!have_min_q ||
			(rd_s1.arrival < min_q.arrival) ||
			((rd_s1.arrival == min_q.arrival) && (rd_s1.burst < min_q.burst)));
	end

	// Candidate payload registers.
	always_ff @(posedge clk) begin
		if (take_best) begin
			best_q     <= rd_s1;
			best_idx_q <= idx_s1;
		end
		if (take_min) begin
			min_q     <= rd_s1;
			min_idx_q <= idx_s1;
		end
	end

	// Chosen job: the best arrived one, otherwise idle to the earliest arrival.
	always_comb begin
		pick_c       = have_best_q ? best_q : min_q;
		pick_idx_c   = have_best_q ? best_idx_q : min_idx_q;
		pick_arr_c   = {{(TICK_W-TIME_W){1'b0}}, pick_c.arrival};
		pick_burst_c = {{(TICK_W-TIME_W){1'b0}}, pick_c.burst};
		pick_start_c = have_best_q ? clock_q : pick_arr_c;
	end

	// Timing arithmetic of the chosen job.
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			sel_q     <= pick_c;
			sel_idx_q <= pick_idx_c;
			start_q   <= pick_start_c;
			finish_q  <= pick_start_c + pick_burst_c;
			wait_q    <= pick_start_c - pick_arr_c;
			turn_q    <= pick_start_c - pick_arr_c + pick_burst_c;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			run.run_id           <= sel_q.id;
			run.run_burst        <= sel_q.burst;
			run.start_tick       <= start_q;
			run.finish_tick      <= finish_q;
			run.wait_ticks       <= wait_q;
			run.turnaround_ticks <= turn_q;
			run.wait_total       <= wait_sum_q + {{(SUM_W-TICK_W){1'b0}}, wait_q};
			run.turnaround_total <= turn_sum_q + {{(SUM_W-TICK_W){1'b0}}, turn_q};
			run.run_last         <= sts.last_pick;
		end
	end

	assign run.valid = out_valid_q;

	// Control state of the batch, the scan and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			emitted_q   <= '0;
			idx_q       <= '0;
			done_q      <= '0;
			clock_q     <= '0;
			wait_sum_q  <= '0;
			turn_sum_q  <= '0;
			vld_s1      <= 1'b0;
			have_best_q <= 1'b0;
			have_min_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_issue;

			// Record count grows until the store is full.
			if (cmd.load && store_room) begin
				count_q <= count_q + CNT_W'(1);
			end

			// Scan address and candidate flags.
			if (cmd.scan_init) begin
				idx_q       <= '0;
				have_best_q <= 1'b0;
				have_min_q  <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (take_best) begin
					have_best_q <= 1'b1;
				end
				if (take_min) begin
					have_min_q <= 1'b1;
				end
			end

			// Commit of one pick, or a fresh batch after the last one.
			if (cmd.clear) begin
				count_q    <= '0;
				emitted_q  <= '0;
				done_q     <= '0;
				clock_q    <= '0;
				wait_sum_q <= '0;
				turn_sum_q <= '0;
			end else if (cmd.emit) begin
				emitted_q         <= emitted_q + CNT_W'(1);
				done_q[sel_idx_q] <= 1'b1;
				clock_q           <= finish_q;
				wait_sum_q        <= wait_sum_q + {{(SUM_W-TICK_W){1'b0}}, wait_q};
				turn_sum_q        <= turn_sum_q + {{(SUM_W-TICK_W){1'b0}}, turn_q};
			end

			// Result register holds until the transaction completes.
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (run.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is only loaded when the register is free.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> sts.out_free)
		else $error("result loaded over a pending transaction");

	// A loaded result is presented in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |=> run.valid)
		else $error("loaded result not presented");

	// Every pick finds a job, arrived or the next to arrive.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.calc |-> (have_best_q || have_min_q))
		else $error("no candidate at the end of a scan");

	// The record count never passes the store capacity.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(N))
		else $error("record count beyond capacity");

endmodule

`default_nettype wire

[hw/rtl/sjf_process_scheduler_core.sv]
// Non-preemptive shortest-job-first scheduler: top level joining controller and datapath.
// Loading accepts one record transaction per cycle while in the load state; records beyond the
// store capacity are dropped. Each pick scans all stored records through one registered store
// read port, then passes the drain and calculation states before loading the result register.
// The next batch's records are accepted while the final result still waits in the output register.
// Asynchronous active-low reset empties the batch and clears the output valid; store contents
// are left as they are and are only read after being written.
`default_nettype none

module sjf_process_scheduler_core (
	input  wire logic clk,
	input  wire logic arst_n,
	sjf_job_if.sink   job,
	sjf_run_if.source run
);

	sjf_pkg::cmd_t    cmd;
	sjf_pkg::status_t sts;
	logic             job_ready;

	assign job.ready = job_ready;

	// Sequencer for load, scan, calculation and emission.
	sjf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job.valid),
		.job_final (job.final_record),
		.job_ready (job_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Store, selection and timing datapath with the result register.
	sjf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.proc_id      (job.proc_id),
		.burst_time   (job.burst_time),
		.arrival_time (job.arrival_time),
		.run          (run)
	);

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the shortest-job-first scheduler core with its own schedule predictor.
`default_nettype none

module testbench;

	localparam int MAX_PROCS = sjf_pkg::MAX_PROCS;
	localparam int IDX_W     = sjf_pkg::IDX_W;
	localparam int ID_W      = sjf_pkg::ID_W;
	localparam int TIME_W    = sjf_pkg::TIME_W;
	localparam int TICK_W    = sjf_pkg::TICK_W;
	localparam int SUM_W     = sjf_pkg::SUM_W;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 9;
	localparam int TAIL_CYCLES    = 64;
	localparam int RUN_LIMIT      = 1000000 * 2 * CLK_HALF;
	localparam int RANDOM_RECORDS = 270;
	localparam int HOLD_OFF_LEN   = 600;
	localparam int REPORT_LIMIT   = 10;

	// How the fields of a random process record are drawn.
	typedef enum int {
		MIX_DENSE,
		MIX_WIDE,
		MIX_SPARSE,
		MIX_EXTREME
	} record_mix_t;

	// One predicted schedule transaction.
	typedef struct packed {
		logic [ID_W-1:0]   run_id;
		logic [TIME_W-1:0] run_burst;
		logic [TICK_W-1:0] start_tick;
		logic [TICK_W-1:0] finish_tick;
		logic [TICK_W-1:0] wait_ticks;
		logic [TICK_W-1:0] turnaround_ticks;
		logic [SUM_W-1:0]  wait_total;
		logic [SUM_W-1:0]  turnaround_total;
		logic              run_last;
	} run_result_t;

	logic clk = 1'b0;
	logic arst_n;

	sjf_job_if job_ch ();
	sjf_run_if run_ch ();

	sjf_process_scheduler_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job_ch),
		.run    (run_ch)
	);

	sjf_pkg::entry_t held_records[$];
	run_result_t     expected_runs[$];
	run_result_t     want_run;
	int              mismatch_count  = 0;
	int              records_sent    = 0;
	int              hold_off_cycles = 0;
	int              sink_gap;
	bit              quiet_mode      = 1'b0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Idle stretches are mostly short, now and then long.
	function automatic int gap_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// A time value that favors the ends of its range.
	function automatic logic [TIME_W-1:0] edge_time();
		case ($urandom_range(0, 2))
			0: return '0;
			1: return '1;
			default: return TIME_W'($urandom);
		endcase
	endfunction

	function automatic sjf_pkg::entry_t make_record(input record_mix_t mix);
		sjf_pkg::entry_t rec;
		rec.id = ID_W'($urandom);
		case (mix)
			MIX_DENSE: begin
				rec.burst   = TIME_W'($urandom_range(0, 15));
				rec.arrival = TIME_W'($urandom_range(0, 31));
			end
			MIX_WIDE: begin
				rec.burst   = TIME_W'($urandom);
				rec.arrival = TIME_W'($urandom);
			end
			MIX_SPARSE: begin
				rec.burst   = TIME_W'($urandom_range(0, 255));
				rec.arrival = TIME_W'($urandom);
			end
			default: begin
				rec.burst   = edge_time();
				rec.arrival = edge_time();
			end
		endcase
		return rec;
	endfunction

	// Shortest arrived job not yet run; ties go to earlier arrival, then load order.
	function automatic int pick_shortest(input bit [MAX_PROCS-1:0] ran,
			input longint unsigned now);
		int best;
		best = -1;
		for (int k = 0; k < held_records.size(); k++) begin
			if (ran[IDX_W'(k)] || 64'(held_records[k].arrival) > now)
				continue;
			if (best < 0 || held_records[k].burst < held_records[best].burst ||
					(held_records[k].burst == held_records[best].burst &&
					held_records[k].arrival < held_records[best].arrival))
				best = k;
		end
		return best;
	endfunction

	function automatic longint unsigned earliest_pending(input bit [MAX_PROCS-1:0] ran);
		longint unsigned soonest;
		soonest = 64'hFFFF_FFFF_FFFF_FFFF;
		for (int k = 0; k < held_records.size(); k++)
			if (!ran[IDX_W'(k)] && 64'(held_records[k].arrival) < soonest)
				soonest = 64'(held_records[k].arrival);
		return soonest;
	endfunction

	// Runs the held batch to completion and queues one expected transaction per job.
	task automatic schedule_batch();
		bit [MAX_PROCS-1:0] ran;
		longint unsigned    now, start, finish, turn, waited, wait_acc, turn_acc;
		int                 sel;
		run_result_t        res;
		ran      = '0;
		now      = '0;
		wait_acc = '0;
		turn_acc = '0;
		for (int n = 0; n < held_records.size(); n++) begin
			sel = pick_shortest(ran, now);
			// Nothing has arrived yet: the clock jumps to the next arrival.
			if (sel < 0) begin
				now = earliest_pending(ran);
				sel = pick_shortest(ran, now);
			end
			start    = now;
			finish   = start + 64'(held_records[sel].burst);
			turn     = finish - 64'(held_records[sel].arrival);
			waited   = turn - 64'(held_records[sel].burst);
			now      = finish;
			wait_acc += waited;
			turn_acc += turn;
			ran[IDX_W'(sel)] = 1'b1;

			res.run_id           = held_records[sel].id;
			res.run_burst        = held_records[sel].burst;
			res.start_tick       = start[TICK_W-1:0];
			res.finish_tick      = finish[TICK_W-1:0];
			res.wait_ticks       = waited[TICK_W-1:0];
			res.turnaround_ticks = turn[TICK_W-1:0];
			res.wait_total       = wait_acc[SUM_W-1:0];
			res.turnaround_total = turn_acc[SUM_W-1:0];
			res.run_last         = (n == held_records.size() - 1);
			expected_runs.push_back(res);
		end
		held_records.delete();
	endtask

	// Stores an accepted record, dropping it when the store is full.
	task automatic predict_record(input sjf_pkg::entry_t rec, input logic fin);
		if (held_records.size() < MAX_PROCS)
			held_records.push_back(rec);
		if (fin)
			schedule_batch();
	endtask

	// Offers one record after an optional gap and waits for its transaction.
	task automatic send_record(input sjf_pkg::entry_t rec, input logic fin);
		int gap;
		gap = (!quiet_mode && $urandom_range(0, 99) < 30) ? gap_length() : 0;
		if (gap > 0) begin
			job_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		job_ch.valid        <= 1'b1;
		job_ch.proc_id      <= rec.id;
		job_ch.burst_time   <= rec.burst;
		job_ch.arrival_time <= rec.arrival;
		job_ch.final_record <= fin;
		do @(posedge clk); while (!job_ch.ready);
		records_sent++;
		predict_record(rec, fin);
	endtask

	task automatic send_direct(input int id, input int burst, input int arrival,
			input logic fin);
		sjf_pkg::entry_t rec;
		rec.id      = ID_W'(id);
		rec.burst   = TIME_W'(burst);
		rec.arrival = TIME_W'(arrival);
		send_record(rec, fin);
	endtask

	task automatic send_batch(input int count, input record_mix_t mix);
		for (int i = 0; i < count; i++)
			send_record(make_record(mix), i == count - 1);
	endtask

	// The sender stays quiet until every expected transaction has come back.
	task automatic drain_results();
		job_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_runs.size() != 0);
	endtask

	// Single job at the top of every range, tie breaking, and idle jumps.
	task automatic test_directed_corners();
		send_direct(255, 16'hFFFF, 16'hFFFF, 1'b1);

		send_direct(0, 0, 0, 1'b0);
		send_direct(1, 5, 3, 1'b0);
		send_direct(2, 5, 1, 1'b0);
		send_direct(3, 5, 1, 1'b0);
		send_direct(4, 16'hFFFF, 0, 1'b1);

		send_direct(10, 2, 100, 1'b0);
		send_direct(11, 1, 500, 1'b1);
		drain_results();
	endtask

	// A full store of the longest jobs, then dropped records, the last of them closing the batch.
	task automatic test_store_overflow();
		for (int i = 0; i < MAX_PROCS; i++)
			send_direct(16 + i, 16'hFFFF, 0, 1'b0);
		send_direct(200, 7, 7, 1'b0);
		send_direct(201, 9, 9, 1'b1);
		drain_results();
	endtask

	// The receiver holds off for a long stretch while full batches keep coming.
	task automatic test_backpressure();
		quiet_mode      = 1'b1;
		hold_off_cycles = HOLD_OFF_LEN;
		send_batch(MAX_PROCS, MIX_WIDE);
		send_batch(MAX_PROCS, MIX_DENSE);
		drain_results();
		quiet_mode = 1'b0;
	endtask

	// Batches back to back with no idling on either side.
	task automatic test_back_to_back();
		quiet_mode = 1'b1;
		send_batch(MAX_PROCS, MIX_EXTREME);
		send_batch(5, MIX_SPARSE);
		send_batch(10, MIX_DENSE);
		drain_results();
		quiet_mode = 1'b0;
	endtask

	// Random batches of random sizes, a few of them overflowing the store.
	task automatic test_random_batches();
		int first, size, r;
		first = records_sent;
		while (records_sent - first < RANDOM_RECORDS) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				size = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
			else if (r < 30)
				size = $urandom_range(1, 3);
			else
				size = $urandom_range(4, MAX_PROCS);
			send_batch(size, record_mix_t'($urandom_range(0, 3)));
			if ($urandom_range(0, 5) == 0)
				drain_results();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Each accepted schedule transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && run_ch.valid && run_ch.ready) begin
			if (expected_runs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected schedule transaction for id %0d", run_ch.run_id);
			end else begin
				want_run = expected_runs.pop_front();
				check_field("run_id", 32'(want_run.run_id), 32'(run_ch.run_id));
				check_field("run_burst", 32'(want_run.run_burst), 32'(run_ch.run_burst));
				check_field("start_tick", 32'(want_run.start_tick), 32'(run_ch.start_tick));
				check_field("finish_tick", 32'(want_run.finish_tick),
					32'(run_ch.finish_tick));
				check_field("wait_ticks", 32'(want_run.wait_ticks), 32'(run_ch.wait_ticks));
				check_field("turnaround_ticks", 32'(want_run.turnaround_ticks),
					32'(run_ch.turnaround_ticks));
				check_field("wait_total", 32'(want_run.wait_total), 32'(run_ch.wait_total));
				check_field("turnaround_total", 32'(want_run.turnaround_total),
					32'(run_ch.turnaround_total));
				check_field("run_last", 32'(want_run.run_last), 32'(run_ch.run_last));
			end
		end
	end

	// Result receiver: a requested long hold-off first, otherwise random stalls.
	initial begin
		run_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				sink_gap        = hold_off_cycles;
				hold_off_cycles = 0;
				run_ch.ready <= 1'b0;
				repeat (sink_gap - 1) @(posedge clk);
			end else if (!quiet_mode && $urandom_range(0, 99) < 30) begin
				sink_gap = gap_length();
				run_ch.ready <= 1'b0;
				repeat (sink_gap - 1) @(posedge clk);
			end else begin
				run_ch.ready <= 1'b1;
			end
		end
	end

	// Reset, the test sequence and the final verdict.
	initial begin
		arst_n              <= 1'b0;
		job_ch.valid        <= 1'b0;
		job_ch.proc_id      <= '0;
		job_ch.burst_time   <= '0;
		job_ch.arrival_time <= '0;
		job_ch.final_record <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_store_overflow();
		test_backpressure();
		test_back_to_back();
		test_random_batches();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#RUN_LIMIT;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/sjf_pkg.sv
hw/rtl/sjf_job_if.sv
hw/rtl/sjf_run_if.sv
hw/rtl/sjf_ctrl.sv
hw/rtl/sjf_dp.sv
hw/rtl/sjf_process_scheduler_core.sv
verif/testbench.sv
